>>> rtl/clx_pkg.sv
// Package for the C source lexer: token record, codes, character classes, tables.
`default_nettype none
package clx_pkg;

	localparam int POSITION_BITS_DEF = 32;
	localparam int QUEUE_DEPTH       = 4;
	localparam int QPTR_BITS         = $clog2(QUEUE_DEPTH);
	localparam int PREFIX_DEPTH      = 6;

	typedef enum logic [2:0] {
		KIND_NUMBER  = 3'd0,
		KIND_IDENT   = 3'd1,
		KIND_KEYWORD = 3'd2,
		KIND_PUNCT   = 3'd3,
		KIND_STRING  = 3'd4,
		KIND_SBYTE   = 3'd5,
		KIND_EOF     = 3'd6,
		KIND_ERROR   = 3'd7
	} tok_kind_t;

	typedef enum logic [1:0] {
		ERR_NONE     = 2'd0,
		ERR_INVALID  = 2'd1,
		ERR_UNCLOSED = 2'd2
	} err_code_t;

	typedef enum logic [2:0] {
		MODE_IDLE   = 3'd0,
		MODE_NUMBER = 3'd1,
		MODE_IDENT  = 3'd2,
		MODE_PUNCT  = 3'd3,
		MODE_STRING = 3'd4,
		MODE_SKIP   = 3'd5
	} lex_mode_t;

	// one result beat
	typedef struct packed {
		tok_kind_t   kind;
		logic [31:0] start;
		logic [31:0] length;
		logic [63:0] value;
		logic [7:0]  data;
		err_code_t   err;
		logic        last;
	} tok_t;

	// records handed from front to back in one cycle
	typedef struct packed {
		logic [1:0] cnt;
		tok_t       first;
		tok_t       second;
	} push_t;

	function automatic logic is_space(input logic [7:0] c);
		return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic is_ident_first(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
	endfunction

	function automatic logic is_punct(input logic [7:0] c);
		return c >= 8'd33 && c <= 8'd126 && !is_digit(c) && !is_ident_first(c)
			&& c != "\"";
	endfunction

	function automatic logic is_pair_lead(input logic [7:0] c);
		return c == "=" || c == "!" || c == "<" || c == ">";
	endfunction

	// mode entered when a byte is seen with no token open
	function automatic lex_mode_t start_mode(input logic [7:0] c);
		lex_mode_t m;
		m = MODE_IDLE;
		if (c == 8'd0 || is_space(c)) m = MODE_IDLE;
		else if (is_digit(c))         m = MODE_NUMBER;
		else if (c == "\"")           m = MODE_STRING;
		else if (is_ident_first(c))   m = MODE_IDENT;
		else if (is_pair_lead(c))     m = MODE_PUNCT;
		else if (is_punct(c))         m = MODE_IDLE;
		else                          m = MODE_SKIP;
		return m;
	endfunction

	function automatic logic [7:0] decode_escape(input logic [7:0] c);
		logic [7:0] r;
		r = c;
		unique case (c)
			"a":     r = 8'd7;
			"b":     r = 8'd8;
			"t":     r = 8'd9;
			"n":     r = 8'd10;
			"v":     r = 8'd11;
			"f":     r = 8'd12;
			"r":     r = 8'd13;
			"e":     r = 8'd27;
			default: r = c;
		endcase
		return r;
	endfunction

	// keyword check on the stored prefix; count 7 means longer than six
	function automatic logic kw_match(input logic [PREFIX_DEPTH-1:0][7:0] pf,
			input logic [2:0] n);
		logic m;
		m = 1'b0;
		unique case (n)
			3'd2: m = pf[0] == "i" && pf[1] == "f";
			3'd3: m = (pf[0] == "f" && pf[1] == "o" && pf[2] == "r")
				|| (pf[0] == "i" && pf[1] == "n" && pf[2] == "t");
			3'd4: m = (pf[0] == "e" && pf[1] == "l" && pf[2] == "s" && pf[3] == "e")
				|| (pf[0] == "c" && pf[1] == "h" && pf[2] == "a" && pf[3] == "r");
			3'd5: m = pf[0] == "w" && pf[1] == "h" && pf[2] == "i" && pf[3] == "l"
				&& pf[4] == "e";
			3'd6: m = (pf[0] == "r" && pf[1] == "e" && pf[2] == "t" && pf[3] == "u"
				&& pf[4] == "r" && pf[5] == "n")
				|| (pf[0] == "s" && pf[1] == "i" && pf[2] == "z" && pf[3] == "e"
				&& pf[4] == "o" && pf[5] == "f");
			default: m = 1'b0;
		endcase
		return m;
	endfunction

endpackage
`default_nettype wire

>>> rtl/clx_byte_if.sv
// Source byte channel.
`default_nettype none
interface clx_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_byte;

	modport source (output valid, output char_byte, input ready);
	modport sink (input valid, input char_byte, output ready);
endinterface
`default_nettype wire

>>> rtl/clx_tok_if.sv
// Token result channel.
`default_nettype none
interface clx_tok_if;
	logic        valid;
	logic        ready;
	logic [2:0]  token_kind;
	logic [31:0] token_start;
	logic [31:0] token_length;
	logic [63:0] number_value;
	logic [7:0]  data_byte;
	logic [1:0]  error_code;
	logic        last;

	modport source (output valid, output token_kind, output token_start,
		output token_length, output number_value, output data_byte,
		output error_code, output last, input ready);
	modport sink (input valid, input token_kind, input token_start,
		input token_length, input number_value, input data_byte,
		input error_code, input last, output ready);
endinterface
`default_nettype wire

>>> rtl/clx_front.sv
// Lexer front: takes source bytes, keeps the scan state, builds up to two records per byte.
`default_nettype none
module clx_front
	import clx_pkg::*;
#(
	parameter int POSITION_BITS = POSITION_BITS_DEF
) (
	input  wire        clk,
	input  wire        arst_n,
	clx_byte_if.sink   chars,
	input  wire        room,
	output push_t      push
);

	localparam int PB = POSITION_BITS;
	localparam int W  = (PB + 1 > 32) ? PB + 1 : 32;

	lex_mode_t                     mode_q, mode_d;
	logic [PB-1:0]                 pos_q, begin_q, begin_d;
	logic [63:0]                   acc_q, acc_d;
	logic [7:0]                    punct_q, punct_d;
	logic [PREFIX_DEPTH-1:0][7:0]  prefix_q, prefix_d;
	logic [2:0]                    idcnt_q, idcnt_d;
	logic                          esc_q, esc_d;
	logic [31:0]                   dcount_q, dcount_d;

	logic        accept;
	logic [7:0]  c;
	logic        v0, v1, again;
	tok_t        rec0, rec1;
	logic [67:0] acc_sum;
	logic [W-1:0] p_w, begin_w, span_w, slen_w, pm1_w;

	assign chars.ready = room;
	assign accept      = chars.valid & room;
	assign c           = chars.char_byte;

	// offsets seen at the 32-bit result fields
	assign p_w     = W'(pos_q);
	assign begin_w = W'(begin_q);
	assign span_w  = W'(pos_q - begin_q);
	assign slen_w  = W'(pos_q - begin_q) + W'(1);
	assign pm1_w   = W'(pos_q - PB'(1));

	// decimal step: acc*10 + digit, overflow shows in the top bits
	assign acc_sum = ({4'd0, acc_q} << 3) + ({4'd0, acc_q} << 1) + 68'(c - "0");

	// next mode
	always_comb begin
		mode_d = mode_q;
		unique case (mode_q)
			MODE_NUMBER: mode_d = is_digit(c) ? MODE_NUMBER : start_mode(c);
			MODE_IDENT:  mode_d = (is_ident_first(c) || is_digit(c)) ? MODE_IDENT
				: start_mode(c);
			MODE_PUNCT:  mode_d = (c == "=") ? MODE_IDLE : start_mode(c);
			MODE_STRING: begin
				if (c == 8'd0)                      mode_d = MODE_IDLE;
				else if (c == 8'd10 && !esc_q)      mode_d = MODE_SKIP;
				else if (c == "\"" && !esc_q)       mode_d = MODE_IDLE;
				else                                mode_d = MODE_STRING;
			end
			MODE_SKIP:   mode_d = (c == 8'd0) ? MODE_IDLE : MODE_SKIP;
			default:     mode_d = start_mode(c);
		endcase
	end

	// records and data state
	always_comb begin
		v0       = 1'b0;
		v1       = 1'b0;
		again    = 1'b0;
		rec0     = '0;
		rec1     = '0;
		begin_d  = begin_q;
		acc_d    = acc_q;
		punct_d  = punct_q;
		prefix_d = prefix_q;
		idcnt_d  = idcnt_q;
		esc_d    = esc_q;
		dcount_d = dcount_q;

		// close or extend the open token
		unique case (mode_q)
			MODE_NUMBER: begin
				if (is_digit(c)) begin
					acc_d = (acc_sum[67:64] != 4'd0) ? '1 : acc_sum[63:0];
				end else begin
					v0    = 1'b1;
					again = 1'b1;
					rec0  = '{KIND_NUMBER, begin_w[31:0], span_w[31:0], acc_q, 8'd0,
						ERR_NONE, 1'b0};
				end
			end
			MODE_IDENT: begin
				if (is_ident_first(c) || is_digit(c)) begin
					if (idcnt_q < 3'(PREFIX_DEPTH)) prefix_d[idcnt_q] = c;
					if (idcnt_q != 3'd7) idcnt_d = idcnt_q + 3'd1;
				end else begin
					v0    = 1'b1;
					again = 1'b1;
					rec0  = '{kw_match(prefix_q, idcnt_q) ? KIND_KEYWORD : KIND_IDENT,
						begin_w[31:0], span_w[31:0], 64'd0, 8'd0, ERR_NONE, 1'b0};
				end
			end
			MODE_PUNCT: begin
				v0    = 1'b1;
				again = (c != "=");
				rec0  = '{KIND_PUNCT, begin_w[31:0], (c == "=") ? 32'd2 : 32'd1, 64'd0,
					punct_q, ERR_NONE, 1'b0};
			end
			MODE_STRING: begin
				if (c == 8'd0 || (c == 8'd10 && !esc_q)) begin
					v0    = 1'b1;
					esc_d = 1'b0;
					rec0  = '{KIND_ERROR, begin_w[31:0], span_w[31:0], 64'd0, 8'd0,
						ERR_UNCLOSED, 1'b0};
				end else if (esc_q) begin
					v0       = 1'b1;
					esc_d    = 1'b0;
					dcount_d = dcount_q + 32'd1;
					rec0     = '{KIND_SBYTE, pm1_w[31:0], 32'd2, 64'd0, decode_escape(c),
						ERR_NONE, 1'b0};
				end else if (c == "\\") begin
					esc_d = 1'b1;
				end else if (c == "\"") begin
					v0   = 1'b1;
					rec0 = '{KIND_STRING, begin_w[31:0], slen_w[31:0], {32'd0, dcount_q},
						8'd0, ERR_NONE, 1'b0};
				end else begin
					v0       = 1'b1;
					dcount_d = dcount_q + 32'd1;
					rec0     = '{KIND_SBYTE, p_w[31:0], 32'd1, 64'd0, c, ERR_NONE, 1'b0};
				end
			end
			MODE_SKIP: begin
			end
			default: again = 1'b1;
		endcase

		// byte seen with no token open
		if (again) begin
			if (c == 8'd0) begin
				v1   = 1'b1;
				rec1 = '{KIND_EOF, p_w[31:0], 32'd0, 64'd0, 8'd0, ERR_NONE, 1'b1};
			end else if (is_space(c)) begin
			end else if (is_digit(c)) begin
				begin_d = pos_q;
				acc_d   = 64'(c - "0");
			end else if (c == "\"") begin
				begin_d  = pos_q;
				dcount_d = 32'd0;
				esc_d    = 1'b0;
			end else if (is_ident_first(c)) begin
				begin_d     = pos_q;
				prefix_d[0] = c;
				idcnt_d     = 3'd1;
			end else if (is_pair_lead(c)) begin
				begin_d = pos_q;
				punct_d = c;
			end else if (is_punct(c)) begin
				v1   = 1'b1;
				rec1 = '{KIND_PUNCT, p_w[31:0], 32'd1, 64'd0, c, ERR_NONE, 1'b1};
			end else begin
				v1   = 1'b1;
				rec1 = '{KIND_ERROR, p_w[31:0], 32'd1, 64'd0, 8'd0, ERR_INVALID, 1'b1};
			end
		end
	end

	// pack valid records, last on the final one
	always_comb begin
		push.cnt         = accept ? (2'(v0) + 2'(v1)) : 2'd0;
		push.first       = v0 ? rec0 : rec1;
		push.first.last  = !(v0 && v1);
		push.second      = rec1;
		push.second.last = 1'b1;
	end

	// state update per accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_IDLE;
			pos_q    <= '0;
			begin_q  <= '0;
			acc_q    <= '0;
			punct_q  <= '0;
			idcnt_q  <= '0;
			esc_q    <= 1'b0;
			dcount_q <= '0;
		end else if (accept) begin
			mode_q   <= mode_d;
			pos_q    <= (c == 8'd0) ? '0 : pos_q + PB'(1);
			begin_q  <= begin_d;
			acc_q    <= acc_d;
			punct_q  <= punct_d;
			idcnt_q  <= idcnt_d;
			esc_q    <= esc_d;
			dcount_q <= dcount_d;
		end
	end

	// identifier prefix is payload, no reset
	always_ff @(posedge clk) begin
		if (accept) prefix_q <= prefix_d;
	end

endmodule
`default_nettype wire

>>> rtl/clx_back.sv
// Lexer back: result queue that takes up to two records a cycle and sends one beat a cycle while tokens.ready is high.
`default_nettype none
module clx_back
	import clx_pkg::*;
(
	input  wire        clk,
	input  wire        arst_n,
	input  push_t      push,
	output logic       room,
	clx_tok_if.source  tokens
);

	tok_t                 mem_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0] wp_q, rp_q;
	logic [QPTR_BITS:0]   count_q;
	logic                 pop;
	tok_t                 head;

	assign room = count_q <= (QPTR_BITS + 1)'(QUEUE_DEPTH - 2);
	assign pop  = tokens.valid && tokens.ready;
	assign head = mem_q[rp_q];

	// output beat straight from the queue head
	assign tokens.valid        = count_q != '0;
	assign tokens.token_kind   = head.kind;
	assign tokens.token_start  = head.start;
	assign tokens.token_length = head.length;
	assign tokens.number_value = head.value;
	assign tokens.data_byte    = head.data;
	assign tokens.error_code   = head.err;
	assign tokens.last         = head.last;

	// record storage
	always_ff @(posedge clk) begin
		if (push.cnt != 2'd0) mem_q[wp_q] <= push.first;
		if (push.cnt == 2'd2) mem_q[QPTR_BITS'(wp_q + 1'b1)] <= push.second;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q    <= '0;
			rp_q    <= '0;
			count_q <= '0;
		end else begin
			wp_q    <= wp_q + QPTR_BITS'(push.cnt);
			rp_q    <= rp_q + QPTR_BITS'(pop);
			count_q <= count_q + (QPTR_BITS + 1)'(push.cnt) - (QPTR_BITS + 1)'(pop);
		end
	end

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (QPTR_BITS + 1)'(QUEUE_DEPTH))
		else $error("result queue overfilled");
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push.cnt != 2'd0 |-> room)
		else $error("records pushed without room");
	a_pair_last: assert property (@(posedge clk) disable iff (!arst_n)
		push.cnt == 2'd2 |-> !push.first.last && push.second.last)
		else $error("last flag wrong on record pair");
	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		push.cnt == 2'd1 |-> push.first.last)
		else $error("single record without last");
`endif

endmodule
`default_nettype wire

>>> rtl/c_source_lexer.sv
// Top level of the C source lexer: front scanner and back result queue.
//
//  channel  dir  handshake     payload
//  chars    in   valid/ready   char_byte
//  tokens   out  valid/ready   token_kind, token_start, token_length,
//                              number_value, data_byte, error_code, last
//
// One source byte per cycle while the result queue has room; each byte is scanned in the cycle it is taken.
// A byte that yields two results needs two output beats, so the output port
// sets the sustained rate.
// chars.ready is high while the four-entry result queue has at least two free entries;
// a stalled output side fills the queue and then holds off input.
// Reset (arst_n) returns the lexer to idle at offset zero; no clearing pass.
`default_nettype none
module c_source_lexer
	import clx_pkg::*;
#(
	parameter int POSITION_BITS = POSITION_BITS_DEF
) (
	input  wire        clk,
	input  wire        arst_n,
	clx_byte_if.sink   chars,
	clx_tok_if.source  tokens
);

	push_t push;
	logic  room;

	clx_front #(
		.POSITION_BITS(POSITION_BITS)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.chars  (chars),
		.room   (room),
		.push   (push)
	);

	clx_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.room   (room),
		.tokens (tokens)
	);

endmodule
`default_nettype wire

>>> tb/tb_c_source_lexer.sv
// Testbench for the C source lexer: directed and random source text against a predictor.
`default_nettype none
module tb_c_source_lexer
	import clx_pkg::*;
();

	localparam int CYCLE_LIMIT  = 200000;
	localparam int RANDOM_BYTES = 180;
	localparam int MAX_REPORTS  = 10;

	logic clk;
	logic arst_n;

	clx_byte_if chars_if();
	clx_tok_if  tok_if();

	c_source_lexer u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.chars  (chars_if),
		.tokens (tok_if)
	);

	// lexer predictor state
	lex_mode_t   lx_mode;
	logic [31:0] lx_pos;
	logic [31:0] lx_begin;
	logic [63:0] lx_acc;
	logic [7:0]  lx_pend;
	logic [7:0]  lx_prefix [7];
	logic [31:0] lx_idcnt;
	logic        lx_esc;
	logic [31:0] lx_dcnt;

	tok_t       tok_q [$];   // tokens still owed by the block
	logic [7:0] text_q [$];  // source text being assembled
	int         fail_cnt  = 0;
	int         cycle_cnt = 0;
	bit         no_gaps   = 0;

	string kw_list [12] = '{"return", "if", "else", "for", "while", "int", "sizeof",
		"char", "returns", "iff", "Int", "cha"};
	string id_set = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
	string esc_keys = "abtnvfre";
	string ws_set = " \t\n\v\f\r";
	string pair_leads = "=!<>";

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// character classes
	function automatic bit sp_char(logic [7:0] c);
		return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
	endfunction

	function automatic bit dig_char(logic [7:0] c);
		return c >= 8'd48 && c <= 8'd57;
	endfunction

	function automatic bit alpha_char(logic [7:0] c);
		return (c >= 8'd97 && c <= 8'd122) || (c >= 8'd65 && c <= 8'd90) || c == 8'd95;
	endfunction

	function automatic bit pn_char(logic [7:0] c);
		return c >= 8'd33 && c <= 8'd126 && !dig_char(c) && !alpha_char(c) && c != 8'd34;
	endfunction

	function automatic logic [7:0] esc_value(logic [7:0] c);
		case (c)
			"a": return 8'd7;
			"b": return 8'd8;
			"t": return 8'd9;
			"n": return 8'd10;
			"v": return 8'd11;
			"f": return 8'd12;
			"r": return 8'd13;
			"e": return 8'd27;
			default: return c;
		endcase
	endfunction

	// keyword lookup on the collected identifier prefix
	function automatic bit kw_hit();
		logic [47:0] w;
		int i;
		w = '0;
		if (lx_idcnt > 32'd6)
			return 1'b0;
		for (i = 0; i < int'(lx_idcnt); i++)
			w = {w[39:0], lx_prefix[i]};
		return (lx_idcnt == 2 && w == "if") || (lx_idcnt == 3 && (w == "for" || w == "int"))
			|| (lx_idcnt == 4 && (w == "else" || w == "char"))
			|| (lx_idcnt == 5 && w == "while")
			|| (lx_idcnt == 6 && (w == "return" || w == "sizeof"));
	endfunction

	function automatic tok_t mk_tok(tok_kind_t k, logic [31:0] s, logic [31:0] l,
			logic [63:0] v, logic [7:0] d, err_code_t e);
		tok_t t;
		t.kind   = k;
		t.start  = s;
		t.length = l;
		t.value  = v;
		t.data   = d;
		t.err    = e;
		t.last   = 1'b0;
		return t;
	endfunction

	function automatic string tok_text(tok_t t);
		return $sformatf("kind=%0d start=%0d length=%0d value=%0d data=%02h err=%0d last=%0d",
			t.kind, t.start, t.length, t.value, t.data, t.err, t.last);
	endfunction

	task automatic reset_model();
		int i;
		lx_mode  = MODE_IDLE;
		lx_pos   = '0;
		lx_begin = '0;
		lx_acc   = '0;
		lx_pend  = '0;
		lx_idcnt = '0;
		lx_esc   = 1'b0;
		lx_dcnt  = '0;
		for (i = 0; i < 7; i++)
			lx_prefix[i] = '0;
	endtask

	// a byte seen with no token open
	task automatic open_token(logic [7:0] c, logic [31:0] p);
		if (c == 8'd0) begin
			tok_q.push_back(mk_tok(KIND_EOF, p, 32'd0, 64'd0, 8'd0, ERR_NONE));
		end else if (sp_char(c)) begin
		end else if (dig_char(c)) begin
			lx_mode  = MODE_NUMBER;
			lx_begin = p;
			lx_acc   = 64'(c - 8'd48);
		end else if (c == 8'd34) begin
			lx_mode  = MODE_STRING;
			lx_begin = p;
			lx_dcnt  = '0;
			lx_esc   = 1'b0;
		end else if (alpha_char(c)) begin
			lx_mode      = MODE_IDENT;
			lx_begin     = p;
			lx_prefix[0] = c;
			lx_idcnt     = 32'd1;
		end else if (c == "=" || c == "!" || c == "<" || c == ">") begin
			lx_mode  = MODE_PUNCT;
			lx_begin = p;
			lx_pend  = c;
		end else if (pn_char(c)) begin
			tok_q.push_back(mk_tok(KIND_PUNCT, p, 32'd1, 64'd0, c, ERR_NONE));
		end else begin
			tok_q.push_back(mk_tok(KIND_ERROR, p, 32'd1, 64'd0, 8'd0, ERR_INVALID));
			lx_mode = MODE_SKIP;
		end
	endtask

	// tokens caused by one accepted source byte
	task automatic predict_byte(logic [7:0] c);
		logic [31:0] p;
		logic [63:0] d;
		int          n0;
		bit          again;
		p     = lx_pos;
		n0    = tok_q.size();
		again = 1'b0;
		case (lx_mode)
			MODE_NUMBER: begin
				if (dig_char(c)) begin
					d = 64'(c - 8'd48);
					if (lx_acc > (64'hFFFF_FFFF_FFFF_FFFF - d) / 64'd10)
						lx_acc = '1;
					else
						lx_acc = lx_acc * 64'd10 + d;
				end else begin
					tok_q.push_back(mk_tok(KIND_NUMBER, lx_begin, p - lx_begin, lx_acc,
						8'd0, ERR_NONE));
					lx_mode = MODE_IDLE;
					again   = 1'b1;
				end
			end
			MODE_IDENT: begin
				if (alpha_char(c) || dig_char(c)) begin
					if (lx_idcnt < 32'd7)
						lx_prefix[lx_idcnt] = c;
					if (lx_idcnt != 32'hFFFF_FFFF)
						lx_idcnt++;
				end else begin
					if (kw_hit())
						tok_q.push_back(mk_tok(KIND_KEYWORD, lx_begin, p - lx_begin, 64'd0,
							8'd0, ERR_NONE));
					else
						tok_q.push_back(mk_tok(KIND_IDENT, lx_begin, p - lx_begin, 64'd0,
							8'd0, ERR_NONE));
					lx_mode = MODE_IDLE;
					again   = 1'b1;
				end
			end
			MODE_PUNCT: begin
				lx_mode = MODE_IDLE;
				if (c == "=") begin
					tok_q.push_back(mk_tok(KIND_PUNCT, lx_begin, 32'd2, 64'd0, lx_pend, ERR_NONE));
				end else begin
					tok_q.push_back(mk_tok(KIND_PUNCT, lx_begin, 32'd1, 64'd0, lx_pend, ERR_NONE));
					again = 1'b1;
				end
			end
			MODE_STRING: begin
				if (c == 8'd0 || (c == 8'd10 && !lx_esc)) begin
					tok_q.push_back(mk_tok(KIND_ERROR, lx_begin, p - lx_begin, 64'd0, 8'd0,
						ERR_UNCLOSED));
					lx_esc = 1'b0;
					if (c == 8'd0)
						lx_mode = MODE_IDLE;
					else
						lx_mode = MODE_SKIP;
				end else if (lx_esc) begin
					lx_esc = 1'b0;
					tok_q.push_back(mk_tok(KIND_SBYTE, p - 32'd1, 32'd2, 64'd0, esc_value(c),
						ERR_NONE));
					lx_dcnt++;
				end else if (c == 8'd92) begin
					lx_esc = 1'b1;
				end else if (c == 8'd34) begin
					tok_q.push_back(mk_tok(KIND_STRING, lx_begin, p - lx_begin + 32'd1,
						64'(lx_dcnt), 8'd0, ERR_NONE));
					lx_mode = MODE_IDLE;
				end else begin
					tok_q.push_back(mk_tok(KIND_SBYTE, p, 32'd1, 64'd0, c, ERR_NONE));
					lx_dcnt++;
				end
			end
			MODE_SKIP: begin
				if (c == 8'd0)
					lx_mode = MODE_IDLE;
			end
			default: begin
				lx_mode = MODE_IDLE;
				again   = 1'b1;
			end
		endcase
		if (again)
			open_token(c, p);
		lx_pos = (c == 8'd0) ? 32'd0 : p + 32'd1;
		if (tok_q.size() > n0)
			tok_q[$].last = 1'b1;
	endtask

	// mostly short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		if (no_gaps)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// drive one source beat and predict it once taken
	task automatic send_byte(logic [7:0] c);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			chars_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		chars_if.valid     <= 1'b1;
		chars_if.char_byte <= c;
		@(posedge clk);
		while (!chars_if.ready)
			@(posedge clk);
		predict_byte(c);
	endtask

	task automatic send_text();
		foreach (text_q[i])
			send_byte(text_q[i]);
		text_q.delete();
	endtask

	// hold off input until every owed token is out
	task automatic wait_drained();
		chars_if.valid <= 1'b0;
		@(posedge clk);
		while (tok_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic void add_byte(logic [7:0] b);
		text_q.push_back(b);
	endfunction

	function automatic void add_str(string s);
		int i;
		for (i = 0; i < s.len(); i++)
			text_q.push_back(s[i]);
	endfunction

	function automatic logic [7:0] rand_pn();
		logic [7:0] c;
		do
			c = 8'($urandom_range(33, 126));
		while (!pn_char(c));
		return c;
	endfunction

	// string body: plain bytes, escapes, and bytes outside printable ASCII
	function automatic void add_str_body(int n);
		int         r;
		logic [7:0] c;
		repeat (n) begin
			r = $urandom_range(0, 99);
			if (r < 60) begin
				do
					c = 8'($urandom_range(32, 126));
				while (c == 8'd34 || c == 8'd92);
				add_byte(c);
			end else if (r < 85) begin
				add_byte(8'd92);
				case ($urandom_range(0, 2))
					0: add_byte(esc_keys[$urandom_range(0, 7)]);
					1: add_byte(8'($urandom_range(33, 126)));
					default: add_byte(8'd10);
				endcase
			end else begin
				do
					c = 8'($urandom_range(1, 255));
				while ((c >= 8'd32 && c <= 8'd126) || c == 8'd10);
				add_byte(c);
			end
		end
	endfunction

	function automatic void add_rand_token();
		int r;
		int n;
		r = $urandom_range(0, 99);
		if (r < 18) begin
			// decimal number, now and then one that saturates
			if ($urandom_range(0, 9) == 0) begin
				case ($urandom_range(0, 2))
					0: add_str("18446744073709551615");
					1: add_str("18446744073709551616");
					default: repeat ($urandom_range(19, 24)) add_byte(8'($urandom_range(48, 57)));
				endcase
			end else begin
				repeat ($urandom_range(1, 4)) add_byte(8'($urandom_range(48, 57)));
			end
		end else if (r < 40) begin
			if ($urandom_range(0, 2) == 0) begin
				add_str(kw_list[$urandom_range(0, 11)]);
			end else begin
				n = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 5);
				add_byte(id_set[$urandom_range(0, 52)]);
				repeat (n - 1) add_byte(id_set[$urandom_range(0, 62)]);
			end
		end else if (r < 60) begin
			if ($urandom_range(0, 1) == 0) begin
				add_byte(pair_leads[$urandom_range(0, 3)]);
				if ($urandom_range(0, 1) == 0)
					add_byte("=");
			end else begin
				add_byte(rand_pn());
			end
		end else if (r < 80) begin
			add_byte(8'd34);
			add_str_body($urandom_range(0, 5));
			add_byte(8'd34);
		end else begin
			repeat ($urandom_range(1, 3)) add_byte(ws_set[$urandom_range(0, 5)]);
		end
		if ($urandom_range(0, 1) == 0)
			add_byte(" ");
	endfunction

	// text that goes wrong part way through
	function automatic void add_broken_text();
		logic [7:0] c;
		repeat ($urandom_range(0, 2)) add_rand_token();
		case ($urandom_range(0, 3))
			0: begin
				add_byte(8'd34);
				add_str_body($urandom_range(0, 3));
				add_byte(8'd10);
			end
			1: begin
				add_byte(8'd34);
				add_str_body($urandom_range(0, 3));
			end
			2: begin
				add_byte(8'd34);
				add_str_body($urandom_range(0, 2));
				add_byte(8'd92);
			end
			default: begin
				do
					c = 8'($urandom_range(1, 255));
				while ((c >= 8'd32 && c <= 8'd126) || sp_char(c));
				add_byte(c);
			end
		endcase
		repeat ($urandom_range(0, 2)) add_rand_token();
	endfunction

	// every token kind but the error, number followed by letters, pair punctuator, escape
	task automatic test_token_kinds();
		add_str("if 12ab>=+\"\\e\"");
		add_byte(8'd0);
		send_text();
	endtask

	// invalid byte, unclosed string at newline, escape cut by end of input
	task automatic test_error_recovery();
		add_byte(8'hFF);
		add_str("z");
		add_byte(8'd0);
		add_str("\"q\n x");
		add_byte(8'd0);
		add_str("\"\\");
		add_byte(8'd0);
		send_text();
	endtask

	task automatic test_random_text();
		int sent;
		int r;
		bit paused;
		sent   = 0;
		paused = 1'b0;
		while (sent < RANDOM_BYTES) begin
			no_gaps = ($urandom_range(0, 4) == 0);
			r = $urandom_range(0, 99);
			if (r < 75)
				repeat ($urandom_range(2, 7)) add_rand_token();
			else if (r < 88)
				add_broken_text();
			else
				repeat ($urandom_range(1, 8)) add_byte(8'($urandom_range(0, 255)));
			add_byte(8'd0);
			sent += text_q.size();
			send_text();
			if (!paused && sent >= RANDOM_BYTES / 2) begin
				wait_drained();
				paused = 1'b1;
			end
		end
		no_gaps = 1'b0;
	endtask

	// token sink with random stalls
	initial begin
		int hold;
		hold = 0;
		tok_if.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold > 0) begin
				tok_if.ready <= 1'b0;
				hold--;
			end else begin
				hold = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
				tok_if.ready <= (hold == 0);
			end
		end
	end

	// compare each token beat against the oldest owed token
	initial begin
		tok_t got;
		tok_t want;
		forever begin
			@(posedge clk);
			if (arst_n && tok_if.valid && tok_if.ready) begin
				got.kind   = tok_kind_t'(tok_if.token_kind);
				got.start  = tok_if.token_start;
				got.length = tok_if.token_length;
				got.value  = tok_if.number_value;
				got.data   = tok_if.data_byte;
				got.err    = err_code_t'(tok_if.error_code);
				got.last   = tok_if.last;
				if (tok_q.size() == 0) begin
					fail_cnt++;
					if (fail_cnt <= MAX_REPORTS)
						$display("%0t: unexpected token %s", $realtime, tok_text(got));
				end else begin
					want = tok_q.pop_front();
					if (got.kind !== want.kind || got.start !== want.start
							|| got.length !== want.length || got.value !== want.value
							|| got.data !== want.data || got.err !== want.err
							|| got.last !== want.last) begin
						fail_cnt++;
						if (fail_cnt <= MAX_REPORTS) begin
							$display("%0t: token mismatch", $realtime);
							$display("  expected %s", tok_text(want));
							$display("  actual   %s", tok_text(got));
						end
					end
				end
			end
		end
	end

	// run limit
	initial begin
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("tb_c_source_lexer NOT OK");
		$finish;
	end

	initial begin
		reset_model();
		arst_n             = 1'b0;
		chars_if.valid     = 1'b0;
		chars_if.char_byte = 8'd0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_token_kinds();
		test_error_recovery();
		wait_drained();
		test_random_text();
		wait_drained();
		repeat (16) @(posedge clk);
		if (fail_cnt == 0 && tok_q.size() == 0)
			$display("tb_c_source_lexer OK");
		else
			$display("tb_c_source_lexer NOT OK");
		$finish;
	end

endmodule
`default_nettype wire

>>> sim.f
rtl/clx_pkg.sv
rtl/clx_byte_if.sv
rtl/clx_tok_if.sv
rtl/clx_front.sv
rtl/clx_back.sv
rtl/c_source_lexer.sv
tb/tb_c_source_lexer.sv
